>>> sv/dmart_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the DMA region table.
// No dependencies; imported by dmart_cell and dma_region_table_unit.
package dmart_pkg;

  localparam int END_W     = 64;  // width of all end-address sums
  localparam int LG_W      = 6;
  localparam int LEN_W     = 32;
  localparam int MIN_W     = 48;
  localparam int MAX_W     = 49;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HI = 2'd1;

  localparam logic [MIN_W-1:0] WIN_LO_RST = '0;
  localparam logic [MAX_W-1:0] WIN_HI_RST = {1'b1, {(MAX_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_REG    = 2'd0,
    MODE_DEREG  = 2'd1,
    MODE_VERIFY = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_RANGE   = 3'd1,
    STAT_OVERLAP = 3'd2,
    STAT_NOTREG  = 3'd3,
    STAT_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    logic     capture;  // latch compare flags for a new transaction
    cell_op_t op;       // shift action applied at end of commit
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_COMMIT
  } state_t;

endpackage

>>> sv/dmart_cell.sv
`timescale 1ns / 1ps
// One table slot: region base, size and valid, plus per-transaction compare flags.
// Depends on dmart_pkg. Chained by dma_region_table_unit.
module dmart_cell import dmart_pkg::*; #(
  parameter int ADDR_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctrl_t           ctrl,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [END_W-1:0]     need_end,
  input  logic [ADDR_BITS-1:0] new_base,
  input  logic [LG_W-1:0]      new_lg,
  input  logic [ADDR_BITS-1:0] left_base,
  input  logic [LG_W-1:0]      left_lg,
  input  logic                 left_valid,
  input  logic                 left_le,
  input  logic [ADDR_BITS-1:0] right_base,
  input  logic [LG_W-1:0]      right_lg,
  input  logic                 right_valid,
  input  logic                 right_le,
  output logic [ADDR_BITS-1:0] base,
  output logic [LG_W-1:0]      lg,
  output logic                 valid,
  output logic                 le,
  output logic                 hit
);

  logic [ADDR_BITS-1:0] base_q;
  logic [LG_W-1:0]      lg_q;
  logic                 valid_q;
  logic                 le_q;
  logic                 cov_q;
  logic [END_W-1:0]     span_end;

  assign span_end = END_W'(base_q) + (END_W'(1) << lg_q);

  // le: this slot is valid and sits at or below the address (prefix of the row).
  // cov: this slot's span reaches the needed end.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
      le_q    <= 1'b0;
      cov_q   <= 1'b0;
    end else begin
      if (ctrl.capture) begin
        le_q  <= valid_q && (base_q <= addr);
        cov_q <= span_end >= need_end;
      end
      case (ctrl.op)
        CELL_INSERT: if (!le_q) valid_q <= left_valid;
        CELL_REMOVE: if (!right_le) valid_q <= right_valid;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (!le_q) begin
          if (left_le) begin
            base_q <= new_base;
            lg_q   <= new_lg;
          end else begin
            base_q <= left_base;
            lg_q   <= left_lg;
          end
        end
      end
      CELL_REMOVE: begin
        if (!right_le) begin
          base_q <= right_base;
          lg_q   <= right_lg;
        end
      end
      default: ;
    endcase
  end

  assign base  = base_q;
  assign lg    = lg_q;
  assign valid = valid_q;
  assign le    = le_q;
  // Nearest slot is the last one with le set.
  assign hit   = le_q && !right_le && cov_q;

endmodule

>>> sv/dma_region_table_unit.sv
`timescale 1ns / 1ps
// Top level of the DMA region table: request decode, status logic, cell row.
// Depends on dmart_pkg and dmart_cell.
//
// Channel   Direction  Handshake                    Payload
// request   in         start & !busy                mode, addr, size_log2, length
// result    out        done (one-cycle strobe)      status, xfer_addr, region_count
// config    in         cfg_valid & cfg_ready        cfg_index, cfg_data
//
// Sequence: a transaction is accepted at an edge; the next cycle is the commit
// cycle (busy high), and the result strobes in the cycle after, in which a new
// transaction may already be accepted. A transaction spans the compare-capture
// edge followed by the commit/shift edge of the cell row.
// Reset (synchronous, active high) clears the valid bits and the region count and
// sets the range registers to their reset values; region payload is never cleared.
// The receiver cannot stall: each result is taken in its strobe cycle.
module dma_region_table_unit import dmart_pkg::*; #(
  parameter int MAX_REGIONS = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           mode,
  input  logic [ADDR_BITS-1:0]                 addr,
  input  logic [LG_W-1:0]                      size_log2,
  input  logic [LEN_W-1:0]                     length,
  output logic                                 done,
  output logic [2:0]                           status,
  output logic [ADDR_BITS-1:0]                 xfer_addr,
  output logic [$clog2(MAX_REGIONS+1)-1:0]     region_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [MAX_W-1:0]                     cfg_data
);

  localparam int CW = $clog2(MAX_REGIONS + 1);

  state_t state, state_next;

  logic [MIN_W-1:0]     win_lo;
  logic [MAX_W-1:0]     win_hi;

  // Request held through the commit cycle.
  logic [1:0]           req_mode;
  logic [ADDR_BITS-1:0] req_addr;
  logic [LG_W-1:0]      req_lg;
  logic [END_W-1:0]     req_end;

  logic [CW-1:0]        total;
  logic [CW-1:0]        total_next;

  logic                 status_valid;
  status_t              status_q;
  status_t              status_next;
  logic [ADDR_BITS-1:0] xfer_addr_q;
  logic [ADDR_BITS-1:0] xfer_addr_next;

  logic                 accept;
  logic [END_W-1:0]     need_end;
  logic                 range_bad;
  logic                 hit_any;
  cell_ctrl_t           ctrl;

  logic [ADDR_BITS-1:0] cell_base  [MAX_REGIONS];
  logic [LG_W-1:0]      cell_lg    [MAX_REGIONS];
  logic                 cell_valid [MAX_REGIONS];
  logic                 cell_le    [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] hit_vec;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // End address the cells compare against; sums cannot wrap in 64 bits.
  always_comb begin
    case (mode)
      MODE_REG:    need_end = END_W'(addr) + (END_W'(1) << size_log2);
      MODE_VERIFY: need_end = END_W'(addr) + END_W'(length);
      default:     need_end = END_W'(addr);
    endcase
  end

  // Config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_lo <= WIN_LO_RST;
      win_hi <= WIN_HI_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIN_LO: win_lo <= cfg_data[MIN_W-1:0];
        REG_WIN_HI: win_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode <= mode;
      req_addr <= addr;
      req_lg   <= size_log2;
      req_end  <= need_end;
    end
  end

  // Cell row. Left of slot 0 acts as a valid entry at or below any address,
  // right of the last slot as an empty one.
  genvar g;
  generate
    for (g = 0; g < MAX_REGIONS; g++) begin : g_cell
      logic [ADDR_BITS-1:0] l_base, r_base;
      logic [LG_W-1:0]      l_lg, r_lg;
      logic                 l_valid, l_le, r_valid, r_le;

      if (g == 0) begin : g_left_end
        assign l_base  = req_addr;
        assign l_lg    = req_lg;
        assign l_valid = 1'b1;
        assign l_le    = 1'b1;
      end else begin : g_left
        assign l_base  = cell_base[g-1];
        assign l_lg    = cell_lg[g-1];
        assign l_valid = cell_valid[g-1];
        assign l_le    = cell_le[g-1];
      end

      if (g == MAX_REGIONS - 1) begin : g_right_end
        assign r_base  = '0;
        assign r_lg    = '0;
        assign r_valid = 1'b0;
        assign r_le    = 1'b0;
      end else begin : g_right
        assign r_base  = cell_base[g+1];
        assign r_lg    = cell_lg[g+1];
        assign r_valid = cell_valid[g+1];
        assign r_le    = cell_le[g+1];
      end

      dmart_cell #(
        .ADDR_BITS(ADDR_BITS)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .addr       (addr),
        .need_end   (need_end),
        .new_base   (req_addr),
        .new_lg     (req_lg),
        .left_base  (l_base),
        .left_lg    (l_lg),
        .left_valid (l_valid),
        .left_le    (l_le),
        .right_base (r_base),
        .right_lg   (r_lg),
        .right_valid(r_valid),
        .right_le   (r_le),
        .base       (cell_base[g]),
        .lg         (cell_lg[g]),
        .valid      (cell_valid[g]),
        .le         (cell_le[g]),
        .hit        (hit_vec[g])
      );
    end
  endgenerate

  // Nearest region covers the needed end.
  assign hit_any = |hit_vec;

  assign range_bad = (req_addr == '0) ||
                     (END_W'(req_addr) < END_W'(win_lo)) ||
                     (req_end > END_W'(win_hi));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commit: pick status, drive the shift, update the count.
  always_comb begin
    state_next     = state;
    ctrl.capture   = accept;
    ctrl.op        = CELL_HOLD;
    status_next    = STAT_RANGE;
    xfer_addr_next = '0;
    total_next     = total;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        state_next = S_IDLE;
        case (req_mode)
          MODE_REG: begin
            if (range_bad) begin
              status_next = STAT_RANGE;
            end else if (hit_any) begin
              status_next = STAT_OVERLAP;
            end else if (total == CW'(MAX_REGIONS)) begin
              status_next = STAT_FULL;
            end else begin
              status_next = STAT_OK;
              ctrl.op     = CELL_INSERT;
              total_next  = total + CW'(1);
            end
          end
          MODE_DEREG: begin
            if (req_addr == '0) begin
              status_next = STAT_RANGE;
            end else if (hit_any) begin
              status_next = STAT_OK;
              ctrl.op     = CELL_REMOVE;
              total_next  = total - CW'(1);
            end else begin
              status_next = STAT_NOTREG;
            end
          end
          MODE_VERIFY: begin
            if (range_bad) begin
              status_next = STAT_RANGE;
            end else if (hit_any) begin
              status_next    = STAT_OK;
              xfer_addr_next = req_addr;
            end else begin
              status_next = STAT_NOTREG;
            end
          end
          default: status_next = STAT_RANGE;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total        <= '0;
      status_valid <= 1'b0;
    end else begin
      total        <= total_next;
      status_valid <= (state == S_COMMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_COMMIT) begin
      status_q    <= status_next;
      xfer_addr_q <= xfer_addr_next;
    end
  end

  assign done         = status_valid;
  assign status       = status_q;
  assign xfer_addr    = xfer_addr_q;
  assign region_count = total;

endmodule

>>> verif/dma_region_table_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for dma_region_table_unit: directed and random requests,
// each result checked against a shadow copy of the region table kept here.
// Depends on dmart_pkg and dma_region_table_unit.
module dma_region_table_unit_test;
  import dmart_pkg::*;

  localparam int REGION_SLOTS = 16;
  localparam int ADDR_W = 48;
  localparam int CNT_W = $clog2(REGION_SLOTS + 1);
  // Mode 3 is not decoded by the block; it must answer out-of-range and change nothing.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] TOP_ADDR = {ADDR_W{1'b1}};
  // A short settle covers the commit of the last transaction.
  localparam int SETTLE_CYCLES = 3;
  // Far longer than any normal gap between transactions, so this only trips on a hang.
  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    status_t          status;
    logic [ADDR_W-1:0] xfer_addr;
    logic [CNT_W-1:0]  region_count;
  } table_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] mode = '0;
  logic [ADDR_W-1:0] addr = '0;
  logic [LG_W-1:0] size_log2 = '0;
  logic [LEN_W-1:0] length = '0;
  logic done;
  logic [2:0] status;
  logic [ADDR_W-1:0] xfer_addr;
  logic [CNT_W-1:0] region_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MAX_W-1:0] cfg_data = '0;

  // Shadow of the region table and the window registers.
  logic [63:0] shadow_base [REGION_SLOTS];
  logic [LG_W-1:0] shadow_lg [REGION_SLOTS];
  int shadow_count = 0;
  logic [MIN_W-1:0] win_min = WIN_LO_RST;
  logic [MAX_W-1:0] win_max = WIN_HI_RST;

  table_answer_t answers_due[$];
  int error_count = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;

  dma_region_table_unit #(
    .MAX_REGIONS(REGION_SLOTS),
    .ADDR_BITS(ADDR_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .addr(addr),
    .size_log2(size_log2),
    .length(length),
    .done(done),
    .status(status),
    .xfer_addr(xfer_addr),
    .region_count(region_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_error(input string field, input logic [63:0] got,
                              input logic [63:0] want);
    $display("%0t mismatch %s: got %0h, want %0h", $time, field, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Shadow table model
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] region_end(input int i);
    return shadow_base[i] + (64'd1 << shadow_lg[i]);
  endfunction

  // Entries with base <= a; the nearest region is the last of them.
  function automatic int regions_at_or_below(input logic [63:0] a);
    int n;
    n = 0;
    while (n < shadow_count && shadow_base[n] <= a) n++;
    return n;
  endfunction

  // Applies one request to the shadow table and returns the answer it must give.
  function automatic table_answer_t compute_table_answer(input logic [1:0] op,
      input logic [ADDR_W-1:0] a, input logic [LG_W-1:0] lg, input logic [LEN_W-1:0] len);
    table_answer_t ans;
    logic [63:0] a64;
    logic [63:0] end_addr;
    int n;
    int i;
    ans.status = STAT_OK;
    ans.xfer_addr = '0;
    a64 = {{(64-ADDR_W){1'b0}}, a};
    n = regions_at_or_below(a64);
    case (op)
      MODE_REG: begin
        end_addr = a64 + (64'd1 << lg);
        if (a64 == 0 || a64 < win_min || end_addr > win_max) begin
          ans.status = STAT_RANGE;
        end else if (n != 0 && region_end(n - 1) >= end_addr) begin
          ans.status = STAT_OVERLAP;
        end else if (shadow_count >= REGION_SLOTS) begin
          ans.status = STAT_FULL;
        end else begin
          // insert after every entry with an equal or lower base
          for (i = shadow_count; i > n; i--) begin
            shadow_base[i] = shadow_base[i - 1];
            shadow_lg[i] = shadow_lg[i - 1];
          end
          shadow_base[n] = a64;
          shadow_lg[n] = lg;
          shadow_count++;
        end
      end
      MODE_DEREG: begin
        // no window check here; an address equal to the region end still hits
        if (a64 == 0) begin
          ans.status = STAT_RANGE;
        end else if (n == 0 || region_end(n - 1) < a64) begin
          ans.status = STAT_NOTREG;
        end else begin
          for (i = n - 1; i + 1 < shadow_count; i++) begin
            shadow_base[i] = shadow_base[i + 1];
            shadow_lg[i] = shadow_lg[i + 1];
          end
          shadow_count--;
        end
      end
      MODE_VERIFY: begin
        end_addr = a64 + {32'd0, len};
        if (a64 == 0 || a64 < win_min || end_addr > win_max) begin
          ans.status = STAT_RANGE;
        end else if (n != 0 && region_end(n - 1) >= end_addr) begin
          ans.xfer_addr = a;
        end else begin
          ans.status = STAT_NOTREG;
        end
      end
      default: begin
        ans.status = STAT_RANGE;
      end
    endcase
    ans.region_count = shadow_count[CNT_W-1:0];
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Request and config drivers
  // ---------------------------------------------------------------------------

  // Holds a request until accepted. Start is left high so back-to-back
  // transactions need no second assignment in the same step.
  task automatic send_request(input logic [1:0] op, input logic [ADDR_W-1:0] a,
                              input logic [LG_W-1:0] lg, input logic [LEN_W-1:0] len);
    start <= 1'b1;
    mode <= op;
    addr <= a;
    size_log2 <= lg;
    length <= len;
    do @(posedge clk); while (busy);
    answers_due.push_back(compute_table_answer(op, a, lg, len));
  endtask

  // Random sender idle cycles ahead of the next transaction.
  task automatic sender_gap();
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic wait_for_idle();
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [MAX_W-1:0] data);
    wait_for_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_WIN_LO) begin
      win_min = data[MIN_W-1:0];
    end else if (idx == REG_WIN_HI) begin
      win_max = data;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------

  // Mostly requests aimed at or near held regions, with a share of wide
  // random addresses, zero addresses and the undecoded mode.
  task automatic random_request();
    logic [1:0] op;
    logic [ADDR_W-1:0] a;
    logic [LG_W-1:0] lg;
    logic [LEN_W-1:0] len;
    logic [63:0] wide;
    int kind;
    int pick;
    logic [31:0] reach;
    bit near;
    kind = $urandom_range(99);
    wide = {$urandom, $urandom};
    near = (shadow_count != 0) && ($urandom_range(3) != 0);
    pick = (shadow_count != 0) ? $urandom_range(shadow_count - 1) : 0;
    if (shadow_count == 0 || shadow_lg[pick] > 30) begin
      reach = 32'hFFFF_FFFF;
    end else begin
      reach = (32'd1 << shadow_lg[pick]) + 32'd16;
    end
    a = ADDR_W'($urandom_range(255, 1)) << 12;
    lg = LG_W'($urandom_range(16, 4));
    len = $urandom_range(4096);
    if (kind < 4) begin
      op = MODE_UNUSED;
      a = wide[ADDR_W-1:0];
      lg = wide[53:48];
      len = $urandom;
    end else if (kind < 44) begin
      op = MODE_REG;
      if ($urandom_range(9) == 0) begin
        a = wide[ADDR_W-1:0];
        lg = LG_W'($urandom_range(63));
      end else if (near && $urandom_range(1)) begin
        a = shadow_base[pick][ADDR_W-1:0] + ADDR_W'($urandom_range(reach));
      end
    end else if (kind < 68) begin
      op = MODE_DEREG;
      if (near) begin
        a = shadow_base[pick][ADDR_W-1:0] + ADDR_W'($urandom_range(reach));
      end else if ($urandom_range(9) == 0) begin
        a = wide[ADDR_W-1:0];
      end
    end else begin
      op = MODE_VERIFY;
      if (near) begin
        a = shadow_base[pick][ADDR_W-1:0] + ADDR_W'($urandom_range(reach));
        len = $urandom_range(reach);
      end else if ($urandom_range(9) == 0) begin
        a = wide[ADDR_W-1:0];
      end
      if ($urandom_range(9) == 0) len = $urandom;
    end
    if ($urandom_range(49) == 0) a = '0;
    send_request(op, a, lg, len);
  endtask

  task automatic run_random_phase(input int items, input int idle_pct);
    sender_idle_pct = idle_pct;
    repeat (items) begin
      sender_gap();
      random_request();
      // occasionally hold the sender until everything has come back
      if ($urandom_range(59) == 0) wait_for_idle();
    end
    sender_idle_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_empty_table();
    send_request(MODE_VERIFY, 48'h1000, '0, 32'd16);
    send_request(MODE_DEREG, '0, '0, '0);
    send_request(MODE_DEREG, 48'h1000, '0, '0);
    send_request(MODE_UNUSED, TOP_ADDR, 6'h3F, 32'hFFFF_FFFF);
    send_request(MODE_REG, '0, 6'd4, '0);
  endtask

  task automatic test_register_edges();
    send_request(MODE_REG, TOP_ADDR, 6'd0, '0);      // ends exactly at the window top
    send_request(MODE_REG, TOP_ADDR, 6'd1, '0);      // one past the top
    send_request(MODE_REG, 48'h10, 6'd63, '0);       // huge size
    send_request(MODE_REG, 48'h1000, 6'd12, '0);
    send_request(MODE_REG, 48'h1000, 6'd4, '0);      // same base, inside
    send_request(MODE_REG, 48'h1800, 6'd8, '0);      // strictly inside
    send_request(MODE_REG, 48'h1000, 6'd13, '0);     // same base, larger: goes after
    send_request(MODE_REG, 48'h800, 6'd4, '0);       // new head of the table
  endtask

  task automatic test_verify_dereg_edges();
    send_request(MODE_VERIFY, 48'h1000, '0, 32'h2000);    // ends on region end
    send_request(MODE_VERIFY, 48'h1000, '0, 32'h2001);
    send_request(MODE_VERIFY, 48'h2800, '0, 32'hFFFF_FFFF);
    send_request(MODE_VERIFY, TOP_ADDR, '0, 32'd1);
    send_request(MODE_VERIFY, TOP_ADDR, '0, 32'd2);       // past the window
    send_request(MODE_VERIFY, '0, '0, 32'd1);
    send_request(MODE_DEREG, 48'h3000, '0, '0);           // address equal to the end
    send_request(MODE_DEREG, 48'h900, '0, '0);            // gap after a region
    send_request(MODE_DEREG, 48'h1FFF, '0, '0);
    send_request(MODE_DEREG, TOP_ADDR, '0, '0);
    send_request(MODE_DEREG, 48'h800, '0, '0);
  endtask

  task automatic test_range_limits();
    write_window_reg(REG_WIN_HI, '0);
    send_request(MODE_REG, 48'h1000, 6'd0, '0);
    send_request(MODE_VERIFY, 48'h1000, '0, '0);
    // bit 48 of the data is beyond the 48-bit minimum register
    write_window_reg(REG_WIN_LO, {1'b1, TOP_ADDR});
    write_window_reg(REG_WIN_HI, {MAX_W{1'b1}});
    send_request(MODE_REG, TOP_ADDR, 6'd47, '0);
    send_request(MODE_VERIFY, TOP_ADDR, '0, 32'hFFFF_FFFF);
    send_request(MODE_REG, 48'h1000, 6'd4, '0);
    send_request(MODE_DEREG, 48'h1000, '0, '0);           // deregister ignores the minimum
    send_request(MODE_DEREG, TOP_ADDR, '0, '0);
    write_window_reg(REG_WIN_LO, MAX_W'(WIN_LO_RST));
    write_window_reg(REG_WIN_HI, WIN_HI_RST);
  endtask

  // Fill all slots, hit the full error and the overlap-before-full order,
  // then empty the table again.
  task automatic test_fill_and_full();
    logic [ADDR_W-1:0] base;
    for (int i = 1; i <= REGION_SLOTS + 1; i++) begin
      base = ADDR_W'(i);
      send_request(MODE_REG, base << 16, 6'd12, '0);
    end
    send_request(MODE_REG, 48'h1_0100, 6'd4, '0);
    send_request(MODE_REG, 48'h2_2000, 6'd12, '0);
    for (int i = 1; i <= REGION_SLOTS; i++) begin
      base = ADDR_W'(i);
      send_request(MODE_DEREG, (base << 16) + 48'h1000, '0, '0);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(200, 0);
    write_window_reg(REG_WIN_LO, 49'h4_0000);
    write_window_reg(REG_WIN_HI, 49'hC_0000);
    run_random_phase(200, 82);
    write_window_reg(REG_WIN_LO, '0);
    write_window_reg(REG_WIN_HI, {MAX_W{1'b1}});
    run_random_phase(180, 6);
    write_window_reg(REG_WIN_LO, 49'd1);
    write_window_reg(REG_WIN_HI, WIN_HI_RST);
    run_random_phase(150, 0);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: one strobe per result, no back-pressure
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    table_answer_t want;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        report_error("unexpected result, status", {61'd0, status}, '0);
      end else begin
        want = answers_due.pop_front();
        if (status !== want.status) begin
          report_error("status", 64'(status), 64'(want.status));
        end
        if (xfer_addr !== want.xfer_addr) begin
          report_error("xfer_addr", 64'(xfer_addr), 64'(want.xfer_addr));
        end
        if (region_count !== want.region_count) begin
          report_error("region_count", 64'(region_count), 64'(want.region_count));
        end
      end
    end
  end

  // Watchdog: any request, result or config transaction resets the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("dma_region_table_unit_test: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_register_edges();
    test_verify_dereg_edges();
    test_range_limits();
    test_fill_and_full();
    test_random_traffic();
    wait_for_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("dma_region_table_unit_test: done, clean");
    end else begin
      $display("dma_region_table_unit_test: done, errors");
    end
    $finish;
  end

endmodule
